/* hw/rtl/flvtsp_pkg.sv */
// Shared types, constants and result layout for the FLV tag statistics parser.
`default_nettype none

package flvtsp_pkg;

    localparam int TOTAL_WIDTH_DEF = 48;
    localparam int FIELD_W         = 48;
    localparam int STAMP_W         = 32;
    localparam int RES_BITS        = 2 + 4 * FIELD_W + STAMP_W;
    localparam int TDATA_W         = ((RES_BITS + 7) / 8) * 8;

    localparam logic [31:0] FLV_MAGIC   = 32'h464C_5601;
    localparam logic [31:0] HDR_LEN     = 32'd9;
    localparam logic [31:0] TRAILER_LEN = 32'd4;
    localparam logic [7:0]  KIND_AUDIO  = 8'd8;
    localparam logic [7:0]  KIND_VIDEO  = 8'd9;
    localparam logic [7:0]  KIND_SCRIPT = 8'd18;

    localparam int DATA_OVERHEAD = 15;
    localparam int AV_OVERHEAD   = 11;

    // byte positions inside multi-byte fields
    localparam logic [3:0] IDX_KIND     = 4'd0;
    localparam logic [3:0] IDX_LEN_B1   = 4'd1;
    localparam logic [3:0] IDX_LEN_B2   = 4'd2;
    localparam logic [3:0] IDX_WORD_END = 4'd3;
    localparam logic [3:0] IDX_STAMP_B0 = 4'd4;
    localparam logic [3:0] IDX_STAMP_B1 = 4'd5;
    localparam logic [3:0] IDX_STAMP_B2 = 4'd6;
    localparam logic [3:0] IDX_STAMP_X  = 4'd7;
    localparam logic [3:0] IDX_HDR_END  = 4'd10;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_FLAGS,
        PH_OFFSET,
        PH_PAD,
        PH_PREV0,
        PH_TAGHDR,
        PH_SKIP,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_SIG,
        ST_ZERO_OFFSET,
        ST_TRUNCATED
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   data_total;
        logic [FIELD_W-1:0]   audio_total;
        logic [FIELD_W-1:0]   video_total;
        logic [STAMP_W-1:0]   duration_ms;
        logic [FIELD_W-1:0]   file_bytes;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/flvtsp_parse.sv */
// FLV header/tag parser with saturating totals; one byte per cycle on i_take.
`default_nettype none

module flvtsp_parse
    import flvtsp_pkg::*;
#(
    parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int TW = TOTAL_WIDTH;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_idx, n_idx;
    logic [31:0]       r_asm, n_asm;
    logic [7:0]        r_kind, n_kind;
    logic [23:0]       r_length, n_length;
    logic [31:0]       r_skip, n_skip;
    logic [TW-1:0]     r_sum_data, n_sum_data;
    logic [TW-1:0]     r_sum_audio, n_sum_audio;
    logic [TW-1:0]     r_sum_video, n_sum_video;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [TW-1:0]     r_bytes, n_bytes;
    t_status           r_err, n_err;

    logic [TW:0]       data_add, audio_add, video_add, bytes_add;
    logic [TW-1:0]     data_sat, audio_sat, video_sat, bytes_sat;
    logic [31:0]       asm_sh;

    // saturating accumulators: carry out of the top bit means clamp
    assign data_add  = {1'b0, r_sum_data} + (TW+1)'(r_length) + (TW+1)'(DATA_OVERHEAD);
    assign audio_add = {1'b0, r_sum_audio} + (TW+1)'(r_length) + (TW+1)'(AV_OVERHEAD);
    assign video_add = {1'b0, r_sum_video} + (TW+1)'(r_length) + (TW+1)'(AV_OVERHEAD);
    assign bytes_add = {1'b0, r_bytes} + (TW+1)'(1);

    assign data_sat  = data_add[TW]  ? '1 : data_add[TW-1:0];
    assign audio_sat = audio_add[TW] ? '1 : audio_add[TW-1:0];
    assign video_sat = video_add[TW] ? '1 : video_add[TW-1:0];
    assign bytes_sat = bytes_add[TW] ? '1 : bytes_add[TW-1:0];

    assign asm_sh = {r_asm[23:0], i_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_idx       <= '0;
            r_asm       <= '0;
            r_kind      <= '0;
            r_length    <= '0;
            r_skip      <= '0;
            r_sum_data  <= '0;
            r_sum_audio <= '0;
            r_sum_video <= '0;
            r_stamp     <= '0;
            r_bytes     <= '0;
            r_err       <= ST_OK;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_asm       <= n_asm;
            r_kind      <= n_kind;
            r_length    <= n_length;
            r_skip      <= n_skip;
            r_sum_data  <= n_sum_data;
            r_sum_audio <= n_sum_audio;
            r_sum_video <= n_sum_video;
            r_stamp     <= n_stamp;
            r_bytes     <= n_bytes;
            r_err       <= n_err;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_asm       = r_asm;
        n_kind      = r_kind;
        n_length    = r_length;
        n_skip      = r_skip;
        n_sum_data  = r_sum_data;
        n_sum_audio = r_sum_audio;
        n_sum_video = r_sum_video;
        n_stamp     = r_stamp;
        n_bytes     = r_bytes;
        n_err       = r_err;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_take) begin
            n_bytes = bytes_sat;
            unique case (r_phase)
                PH_SIG: begin
                    n_asm = asm_sh;
                    if (r_idx == IDX_WORD_END) begin
                        n_idx = '0;
                        if (asm_sh != FLV_MAGIC) begin
                            n_err   = ST_BAD_SIG;
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_FLAGS: begin
                    n_phase = PH_OFFSET;
                    n_idx   = '0;
                    n_asm   = '0;
                end
                PH_OFFSET: begin
                    n_asm = asm_sh;
                    if (r_idx == IDX_WORD_END) begin
                        n_idx = '0;
                        if (asm_sh == '0) begin
                            n_err   = ST_ZERO_OFFSET;
                            n_phase = PH_ERROR;
                        end else if (asm_sh > HDR_LEN) begin
                            n_skip  = asm_sh - HDR_LEN;
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_PREV0;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_PAD: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == '0) begin
                        n_phase = PH_PREV0;
                        n_idx   = '0;
                    end
                end
                PH_PREV0: begin
                    if (r_idx == IDX_WORD_END) begin
                        n_idx   = '0;
                        n_phase = PH_TAGHDR;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_TAGHDR: begin
                    unique case (r_idx)
                        IDX_KIND: begin
                            n_kind = i_byte;
                            n_asm  = '0;
                        end
                        IDX_LEN_B1, IDX_LEN_B2: n_asm = asm_sh;
                        IDX_WORD_END: begin
                            n_asm    = asm_sh;
                            n_length = asm_sh[23:0];
                        end
                        IDX_STAMP_B0: n_asm = {24'd0, i_byte};
                        IDX_STAMP_B1, IDX_STAMP_B2: n_asm = asm_sh;
                        // extended timestamp byte lands on top
                        IDX_STAMP_X: n_asm = {i_byte, r_asm[23:0]};
                        default: ;
                    endcase
                    if (r_idx == IDX_HDR_END) begin
                        n_stamp = r_asm;
                        if (r_kind != KIND_SCRIPT) n_sum_data = data_sat;
                        if (r_kind == KIND_AUDIO) n_sum_audio = audio_sat;
                        else if (r_kind == KIND_VIDEO) n_sum_video = video_sat;
                        n_skip  = 32'(r_length) + TRAILER_LEN;
                        n_idx   = '0;
                        n_phase = PH_SKIP;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == '0) begin
                        n_idx   = '0;
                        n_phase = PH_TAGHDR;
                    end
                end
                PH_ERROR: ;
                default: ;
            endcase

            if (i_last) begin
                o_res_valid       = 1'b1;
                if (n_err != ST_OK) o_res.status = n_err;
                else if (n_phase <= PH_PREV0) o_res.status = ST_TRUNCATED;
                else o_res.status = ST_OK;
                o_res.data_total  = FIELD_W'(n_sum_data);
                o_res.audio_total = FIELD_W'(n_sum_audio);
                o_res.video_total = FIELD_W'(n_sum_video);
                o_res.duration_ms = n_stamp;
                o_res.file_bytes  = FIELD_W'(n_bytes);

                // end of file: back to the reset state for the next one
                n_phase     = PH_SIG;
                n_idx       = '0;
                n_asm       = '0;
                n_kind      = '0;
                n_length    = '0;
                n_skip      = '0;
                n_sum_data  = '0;
                n_sum_audio = '0;
                n_sum_video = '0;
                n_stamp     = '0;
                n_bytes     = '0;
                n_err       = ST_OK;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) == (r_phase == PH_ERROR))
        else $error("error code and error phase disagree");

    a_skip_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD || r_phase == PH_SKIP) |-> (r_skip != '0))
        else $error("skip count empty while skipping");

    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAGHDR) |-> (r_idx <= IDX_HDR_END))
        else $error("tag header index out of range");

    a_no_sums_before_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase <= PH_PREV0 || r_phase == PH_ERROR) |->
            (r_sum_data == '0 && r_sum_audio == '0 && r_sum_video == '0))
        else $error("totals moved before the first tag");
`endif

endmodule

`default_nettype wire

/* hw/rtl/flvtsp_obuf.sv */
// Output register with one skid entry for the summary word.
`default_nettype none

module flvtsp_obuf
    import flvtsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_res
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_pop_ready) begin
            // output slot frees up: refill from skid first, then from input
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = i_res;
                n_skid_valid = i_push;
            end else begin
                n_out        = i_res;
                n_out_valid  = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

/* hw/rtl/flv_tag_stats_parser.sv */
// Top level of the FLV tag statistics parser: byte stream in, summary word out.
`default_nettype none

// Takes one FLV file byte per cycle while o_s_tready is high and returns one
// summary word per file, on the byte marked tlast. Every byte is parsed in
// the cycle it is accepted (header check, padding skip, 11-byte tag headers,
// saturating totals), so the input sustains one byte per clock while
// o_s_tready is high. The summary is registered for the master side; one skid
// entry stands behind the output register, and o_s_tready drops only when
// both hold a summary the sink has not taken. Status codes: 0 ok, 1 bad
// signature, 2 zero data offset, 3 file ended before the first tag.
module flv_tag_stats_parser
    import flvtsp_pkg::*;
#(
    parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // [7:0] byte_in
    input  wire logic               i_s_tlast,   // is_last
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    // [1:0] status, [49:2] data_total, [97:50] audio_total,
    // [145:98] video_total, [177:146] duration_ms, [225:178] file_bytes
    output logic [TDATA_W-1:0]      o_m_tdata
);

    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign take = i_s_tvalid && o_s_tready;

    flvtsp_parse #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    flvtsp_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = {{(TDATA_W - RES_BITS){1'b0}},
                        out_res.file_bytes,
                        out_res.duration_ms,
                        out_res.video_total,
                        out_res.audio_total,
                        out_res.data_total,
                        out_res.status};

endmodule

`default_nettype wire
